// File: sv/pwfd_pkg.sv
// shared types, register indexes and reset values of the pulse-width frame decoder
package pwfd_pkg;

	localparam int unsigned CfgW      = 16;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned TimeW     = 32;
	localparam int unsigned ByteW     = 8;
	localparam int unsigned PosW      = 5;
	localparam int unsigned DataBits  = 8;
	localparam int unsigned ParityPos = 16;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_START_MIN   = 3'd0;
	localparam cfg_idx_t REG_PULSE_MAX   = 3'd1;
	localparam cfg_idx_t REG_PULSE_MIN   = 3'd2;
	localparam cfg_idx_t REG_SHORT_LIMIT = 3'd3;
	localparam cfg_idx_t REG_LONG_LIMIT  = 3'd4;
	localparam cfg_idx_t REG_SPACE_MIN   = 3'd5;

	localparam logic [CfgW-1:0] RST_START_MIN   = 16'd2500;
	localparam logic [CfgW-1:0] RST_PULSE_MAX   = 16'd330;
	localparam logic [CfgW-1:0] RST_PULSE_MIN   = 16'd149;
	localparam logic [CfgW-1:0] RST_SHORT_LIMIT = 16'd166;
	localparam logic [CfgW-1:0] RST_LONG_LIMIT  = 16'd294;
	localparam logic [CfgW-1:0] RST_SPACE_MIN   = 16'd300;

	typedef enum logic [2:0] {
		ST_NONE   = 3'd0,
		ST_ACCEPT = 3'd1,
		ST_PARITY = 3'd2,
		ST_ERROR  = 3'd3,
		ST_START  = 3'd4
	} status_t;

	typedef struct packed {
		logic [CfgW-1:0] start_min_us;
		logic [CfgW-1:0] pulse_max_us;
		logic [CfgW-1:0] pulse_min_us;
		logic [CfgW-1:0] short_limit_us;
		logic [CfgW-1:0] long_limit_us;
		logic [CfgW-1:0] space_min_us;
	} cfg_t;

	typedef struct packed {
		logic [ByteW-1:0] inputs_now;
		logic [ByteW-1:0] change_mask;
		status_t          status;
		logic             notify;
	} res_t;

endpackage

// File: sv/pwfd_cfg_regs.sv
// configuration register file of the pulse-width frame decoder
module pwfd_cfg_regs import pwfd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  cfg_idx_t        cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_min_us   <= RST_START_MIN;
			cfg_q.pulse_max_us   <= RST_PULSE_MAX;
			cfg_q.pulse_min_us   <= RST_PULSE_MIN;
			cfg_q.short_limit_us <= RST_SHORT_LIMIT;
			cfg_q.long_limit_us  <= RST_LONG_LIMIT;
			cfg_q.space_min_us   <= RST_SPACE_MIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_MIN:   cfg_q.start_min_us   <= cfg_data;
				REG_PULSE_MAX:   cfg_q.pulse_max_us   <= cfg_data;
				REG_PULSE_MIN:   cfg_q.pulse_min_us   <= cfg_data;
				REG_SHORT_LIMIT: cfg_q.short_limit_us <= cfg_data;
				REG_LONG_LIMIT:  cfg_q.long_limit_us  <= cfg_data;
				REG_SPACE_MIN:   cfg_q.space_min_us   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: sv/pwfd_core.sv
// frame decode state and the per-beat next-state logic for edges and mask reads
module pwfd_core import pwfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic             mode,
	input  logic             level,
	input  logic [TimeW-1:0] time_us,
	input  cfg_t             cfg,
	output res_t             res
);

	logic [PosW-1:0]  bit_pos_q,   bit_pos_d;
	logic             hunting_q,   hunting_d;
	logic [TimeW-1:0] rise_time_q, rise_time_d;
	logic [TimeW-1:0] fall_time_q, fall_time_d;
	logic [ByteW-1:0] frame_bits_q, frame_bits_d;
	logic             parity_q,    parity_d;
	logic [ByteW-1:0] accepted_q,  accepted_d;
	logic [ByteW-1:0] sticky_q,    sticky_d;

	logic [TimeW-1:0] pulse_len;
	logic [TimeW-1:0] gap_len;
	logic             width_bad;
	logic             is_zero;
	status_t          status;
	logic             notify;

	assign pulse_len = time_us - rise_time_q;
	assign gap_len   = time_us - fall_time_q;

	assign width_bad = (pulse_len > TimeW'(cfg.pulse_max_us))
		|| (pulse_len < TimeW'(cfg.pulse_min_us))
		|| ((pulse_len > TimeW'(cfg.short_limit_us))
			&& (pulse_len < TimeW'(cfg.long_limit_us)));
	assign is_zero = pulse_len > TimeW'(cfg.long_limit_us);

	always_comb begin
		bit_pos_d    = bit_pos_q;
		hunting_d    = hunting_q;
		rise_time_d  = rise_time_q;
		fall_time_d  = fall_time_q;
		frame_bits_d = frame_bits_q;
		parity_d     = parity_q;
		accepted_d   = accepted_q;
		sticky_d     = sticky_q;
		status       = ST_NONE;
		notify       = 1'b0;

		if (mode) begin
			// read and clear
			sticky_d = '0;
		end else if (level) begin
			rise_time_d = time_us;
			if (!hunting_q && (gap_len < TimeW'(cfg.space_min_us))) begin
				hunting_d = 1'b1;
				status    = ST_ERROR;
			end
		end else begin
			fall_time_d = time_us;
			if (hunting_q) begin
				if (pulse_len > TimeW'(cfg.start_min_us)) begin
					hunting_d    = 1'b0;
					bit_pos_d    = '0;
					frame_bits_d = '0;
					parity_d     = 1'b0;
					status       = ST_START;
				end
			end else if (width_bad) begin
				hunting_d = 1'b1;
				status    = ST_ERROR;
			end else if (bit_pos_q >= PosW'(ParityPos)) begin
				hunting_d = 1'b1;
				if (is_zero ^ parity_q) begin
					status = ST_PARITY;
				end else begin
					sticky_d   = sticky_q | (accepted_q ^ frame_bits_q);
					accepted_d = frame_bits_q;
					notify     = |sticky_d;
					status     = ST_ACCEPT;
				end
			end else begin
				if ((bit_pos_q < PosW'(DataBits))
					&& (pulse_len < TimeW'(cfg.short_limit_us))) begin
					frame_bits_d[bit_pos_q[2:0]] = 1'b1;
					parity_d = ~parity_q;
				end
				bit_pos_d = bit_pos_q + PosW'(1);
			end
		end
	end

	assign res.inputs_now  = accepted_d;
	assign res.change_mask = mode ? sticky_q : sticky_d;
	assign res.status      = status;
	assign res.notify      = notify;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q    <= '0;
			hunting_q    <= 1'b1;
			rise_time_q  <= '0;
			fall_time_q  <= '0;
			frame_bits_q <= '0;
			parity_q     <= 1'b0;
			accepted_q   <= '0;
			sticky_q     <= '0;
		end else if (step_en) begin
			bit_pos_q    <= bit_pos_d;
			hunting_q    <= hunting_d;
			rise_time_q  <= rise_time_d;
			fall_time_q  <= fall_time_d;
			frame_bits_q <= frame_bits_d;
			parity_q     <= parity_d;
			accepted_q   <= accepted_d;
			sticky_q     <= sticky_d;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q <= PosW'(ParityPos))
		else $error("bit position past parity slot");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && status == ST_START) |=> (bit_pos_q == '0 && !hunting_q
			&& frame_bits_q == '0 && !parity_q))
		else $error("frame start did not clear the bit counters");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && mode) |=> (sticky_q == '0))
		else $error("mask read did not clear the change mask");

endmodule

// File: sv/pulse_width_frame_decoder_unit.sv
// top level of the pulse-width frame decoder: input stage, decode core, result register
//
// Decodes a pulse-width-coded eight-input line from timestamped edges. Each
// input beat is either a line edge (mode 0, with the level after the edge and
// a free-running microsecond timestamp) or a read-and-clear of the sticky
// change mask (mode 1). Every input beat yields exactly one result beat with
// the current input byte, the change mask (before any clear), a frame status
// and a notify flag. A beat is registered at the input, decoded combinationally
// against the frame state and the limit registers, and lands in the result
// register, so one beat per cycle is sustained while the output is not stalled.
// The result register holds the result beat and frees up in the
// same cycle it is taken, so a stalled output holds back at most the one beat in
// the input stage. The six 16-bit limit registers are written through the config
// channel (index 0 start_min_us through 5 space_min_us); cfg_ready is always
// high and writes to other indexes are dropped. Limits should be changed only
// while no beats are in flight.
module pulse_width_frame_decoder_unit import pwfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,

	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	input  logic             level,
	input  logic [TimeW-1:0] time_us,

	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ByteW-1:0] inputs_now,
	output logic [ByteW-1:0] change_mask,
	output logic [2:0]       frame_status,
	output logic             notify,

	// config write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [CfgW-1:0]  cfg_data
);

	cfg_t             cfg;
	res_t             res;

	// input stage
	logic             valid_s1;
	logic             mode_s1;
	logic             level_s1;
	logic [TimeW-1:0] time_s1;

	// result register
	logic             out_valid_q;
	res_t             res_q;

	logic             out_free;
	logic             advance;
	logic             in_take;

	// result register can load when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	// beat in the input stage moves through the decoder
	assign advance  = valid_s1 && out_free;
	// input stage refills when empty or emptying
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	pwfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwfd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.mode    (mode_s1),
		.level   (level_s1),
		.time_us (time_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1  <= mode;
			level_s1 <= level;
			time_s1  <= time_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign inputs_now   = res_q.inputs_now;
	assign change_mask  = res_q.change_mask;
	assign frame_status = res_q.status;
	assign notify       = res_q.notify;

	a_notify_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.notify) |->
			(res_q.status == ST_ACCEPT && res_q.change_mask != '0))
		else $error("notify without an accepted frame and a nonzero mask");

	a_no_beat_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage dropped a beat that was not decoded");

endmodule
